FILE: src/ezr_pkg.sv
// Shared types, constants and rounding helpers for the ZXZ Euler rotation block.
// No dependencies; every other file imports this package.
package ezr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int SQRT_BITS        = 31;

  localparam logic signed [33:0] HALF_PI_Q30  = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [15:0] COS_ONE      = 16'sd16384;
  localparam logic signed [31:0] SAT_MAX      = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN      = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] c2;
    vec_t               v;
  } pay_t;

  typedef struct packed {
    pay_t               pay;
    logic signed [33:0] z1;
    logic signed [33:0] z3;
    logic               flip1;
    logic               flip3;
  } sq_side_t;

  typedef struct packed {
    pay_t               pay;
    logic signed [31:0] s2;
    logic               flip1;
    logic               flip3;
  } cd_side_t;

  typedef struct packed {
    logic signed [33:0] x1;
    logic signed [33:0] y1;
    logic signed [33:0] z1;
    logic signed [33:0] x3;
    logic signed [33:0] y3;
    logic signed [33:0] z3;
  } cd_st_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0:  r = 34'sh3243F6A8;
      5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;
      5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;
      5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;
      5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;
      5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;
      5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;
      5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;
      5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;
      5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;
      5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;
      5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;
      5'd23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round half up from Q.60 product to Q.30
  function automatic logic signed [37:0] rnd30(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = (p + 68'sd536870912) >>> 30;
    return t[37:0];
  endfunction

  // Product with a Q1.14 cosine back to Q.30
  function automatic logic signed [37:0] rnd14(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = (p + 68'sd8192) >>> 14;
    return t[37:0];
  endfunction

endpackage

FILE: src/ezr_sqrt_cell.sv
// One bit of a pipelined restoring square root; passes side data along.
// Depends on ezr_pkg.
module ezr_sqrt_cell
  import ezr_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [60:0] rem_i,
  input  logic [30:0] root_i,
  input  sq_side_t    side_i,
  output logic        vld_o,
  output logic [60:0] rem_o,
  output logic [30:0] root_o,
  output sq_side_t    side_o
);

  logic [62:0] trial;
  logic [62:0] rem_ext;
  logic        take;
  logic [60:0] rem_nxt;
  logic [30:0] root_nxt;

  always_comb begin
    trial    = ({32'd0, root_i} << (BIT + 1)) + (63'd1 << (2 * BIT));
    rem_ext  = {2'b00, rem_i};
    take     = rem_ext >= trial;
    rem_nxt  = take ? 61'(rem_ext - trial) : rem_i;
    root_nxt = take ? (root_i | (31'd1 << BIT)) : root_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
      side_o <= side_i;
    end
  end

endmodule

FILE: src/ezr_cordic_cell.sv
// One rotation-mode CORDIC step for both Euler angles at once.
// Depends on ezr_pkg (arctangent table).
module ezr_cordic_cell
  import ezr_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     vld_i,
  input  cd_st_t   st_i,
  input  cd_side_t side_i,
  output logic     vld_o,
  output cd_st_t   st_o,
  output cd_side_t side_o
);

  localparam logic signed [33:0] ATAN = atan_q30(5'(STEP));

  cd_st_t st_nxt;

  always_comb begin
    st_nxt = st_i;
    if (!st_i.z1[33]) begin
      st_nxt.x1 = st_i.x1 - (st_i.y1 >>> STEP);
      st_nxt.y1 = st_i.y1 + (st_i.x1 >>> STEP);
      st_nxt.z1 = st_i.z1 - ATAN;
    end else begin
      st_nxt.x1 = st_i.x1 + (st_i.y1 >>> STEP);
      st_nxt.y1 = st_i.y1 - (st_i.x1 >>> STEP);
      st_nxt.z1 = st_i.z1 + ATAN;
    end
    if (!st_i.z3[33]) begin
      st_nxt.x3 = st_i.x3 - (st_i.y3 >>> STEP);
      st_nxt.y3 = st_i.y3 + (st_i.x3 >>> STEP);
      st_nxt.z3 = st_i.z3 - ATAN;
    end else begin
      st_nxt.x3 = st_i.x3 + (st_i.y3 >>> STEP);
      st_nxt.y3 = st_i.y3 - (st_i.x3 >>> STEP);
      st_nxt.z3 = st_i.z3 + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_o   <= st_nxt;
      side_o <= side_i;
    end
  end

endmodule

FILE: src/ezr_matrix.sv
// Builds the ZXZ matrix from sines and cosines and applies it to the vector.
// Four register stages: pair products, cosine terms, entry times component, row sums.
// Depends on ezr_pkg.
module ezr_matrix
  import ezr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  cd_st_t             st_i,
  input  cd_side_t           side_i,
  output logic               vld_o,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic               sat
);

  // stage 1: products of two unit-circle values
  logic signed [33:0] c1, s1, c3, s3, s2;
  logic signed [33:0] c1c3_r, c1s3_r, s1s3_r, s1c3_r, s1s2_r, c1s2_r, s2s3_r, s2c3_r;
  pay_t               pay1_r, pay2_r;
  logic [3:0]         vld_r;

  always_comb begin
    c1 = side_i.flip1 ? -st_i.x1 : st_i.x1;
    s1 = side_i.flip1 ? -st_i.y1 : st_i.y1;
    c3 = side_i.flip3 ? -st_i.x3 : st_i.x3;
    s3 = side_i.flip3 ? -st_i.y3 : st_i.y3;
    s2 = 34'(side_i.s2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1c3_r <= 34'(rnd30(68'(c1) * 68'(c3)));
      c1s3_r <= 34'(rnd30(68'(c1) * 68'(s3)));
      s1s3_r <= 34'(rnd30(68'(s1) * 68'(s3)));
      s1c3_r <= 34'(rnd30(68'(s1) * 68'(c3)));
      s1s2_r <= 34'(rnd30(68'(s1) * 68'(s2)));
      c1s2_r <= 34'(rnd30(68'(c1) * 68'(s2)));
      s2s3_r <= 34'(rnd30(68'(s2) * 68'(s3)));
      s2c3_r <= 34'(rnd30(68'(s2) * 68'(c3)));
      pay1_r <= side_i.pay;
    end
  end

  // stage 2: matrix entries
  logic signed [34:0] m_r [0:7];
  logic signed [67:0] c2w;

  assign c2w = 68'(pay1_r.c2);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= 35'(c1c3_r) - 35'(rnd14(c2w * 68'(s1s3_r)));
      m_r[1] <= 35'(c1s3_r) + 35'(rnd14(c2w * 68'(s1c3_r)));
      m_r[2] <= 35'(s1s2_r);
      m_r[3] <= -35'(s1c3_r) - 35'(rnd14(c2w * 68'(c1s3_r)));
      m_r[4] <= -35'(s1s3_r) + 35'(rnd14(c2w * 68'(c1c3_r)));
      m_r[5] <= 35'(c1s2_r);
      m_r[6] <= 35'(s2s3_r);
      m_r[7] <= -35'(s2c3_r);
      pay2_r <= pay1_r;
    end
  end

  // stage 3: each entry times its vector component
  logic signed [37:0] t_r [0:8];
  logic signed [67:0] vx, vy, vz;

  always_comb begin
    vx = 68'(pay2_r.v.x);
    vy = 68'(pay2_r.v.y);
    vz = 68'(pay2_r.v.z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= rnd30(68'(m_r[0]) * vx);
      t_r[1] <= rnd30(68'(m_r[1]) * vy);
      t_r[2] <= rnd30(68'(m_r[2]) * vz);
      t_r[3] <= rnd30(68'(m_r[3]) * vx);
      t_r[4] <= rnd30(68'(m_r[4]) * vy);
      t_r[5] <= rnd30(68'(m_r[5]) * vz);
      t_r[6] <= rnd30(68'(m_r[6]) * vx);
      t_r[7] <= rnd30(68'(m_r[7]) * vy);
      t_r[8] <= rnd14(68'(pay2_r.c2) * vz);
    end
  end

  // stage 4: row sums and clipping
  logic signed [39:0] sum [0:2];
  logic signed [31:0] r_nxt [0:2];
  logic [2:0]         clip;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = 40'(t_r[3*k]) + 40'(t_r[3*k+1]) + 40'(t_r[3*k+2]);
      if (sum[k] > 40'(SAT_MAX)) begin
        r_nxt[k] = SAT_MAX;
        clip[k]  = 1'b1;
      end else if (sum[k] < 40'(SAT_MIN)) begin
        r_nxt[k] = SAT_MIN;
        clip[k]  = 1'b1;
      end else begin
        r_nxt[k] = sum[k][31:0];
        clip[k]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_x <= r_nxt[0];
      rot_y <= r_nxt[1];
      rot_z <= r_nxt[2];
      sat   <= |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  assign vld_o = vld_r[3];

endmodule

FILE: src/euler_zxz_vector_rotation.sv
// Top level of the ZXZ Euler rotation: input stage, square-root and CORDIC cell chains,
// matrix unit. Depends on ezr_pkg, ezr_sqrt_cell, ezr_cordic_cell, ezr_matrix.
//
//  channel  dir  handshake          payload
//  in_      in   tvalid / tready    tdata: angles, middle cosine, vector
//  out_     out  tvalid / tready    tdata: rotated vector; tuser: saturated flag
//
// One item per cycle while the output is not stalled; the chain is the input stage,
// the 31 square-root bit cells, one CORDIC cell per step and the matrix unit.
// rst_n (synchronous) clears the valid bits only; data registers hold garbage.
// A stalled output freezes the whole chain; the input is taken whenever the
// output register is empty or being drained.
module euler_zxz_vector_rotation
  import ezr_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [14:0] first_angle, [30:15] middle_cosine, [45:31] third_angle,
  // [77:46] vec_x, [109:78] vec_y, [141:110] vec_z, [143:142] zero
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] rot_x, [63:32] rot_y, [95:64] rot_z
  output logic [95:0]  out_tdata,
  // [0] saturated
  output logic [0:0]   out_tuser
);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // input stage: clip cosine, form radicand, fold angles into +-pi/2
  logic signed [15:0] c2_raw, c2_clip;
  logic signed [33:0] a1, a3;
  logic [31:0]        c2_sq;
  sq_side_t           side_nxt;
  logic               v0_r;
  logic [60:0]        rem0_r;
  sq_side_t           side0_r;

  always_comb begin
    c2_raw  = $signed(in_tdata[30:15]);
    if (c2_raw > COS_ONE) begin
      c2_clip = COS_ONE;
    end else if (c2_raw < -COS_ONE) begin
      c2_clip = -COS_ONE;
    end else begin
      c2_clip = c2_raw;
    end
    c2_sq = 32'(32'(c2_clip) * 32'(c2_clip));
    a1    = 34'($signed(in_tdata[14:0])) <<< 18;
    a3    = 34'($signed(in_tdata[45:31])) <<< 18;
    side_nxt.pay.c2  = c2_clip;
    side_nxt.pay.v.x = $signed(in_tdata[77:46]);
    side_nxt.pay.v.y = $signed(in_tdata[109:78]);
    side_nxt.pay.v.z = $signed(in_tdata[141:110]);
    side_nxt.z1      = a1;
    side_nxt.flip1   = 1'b0;
    if (a1 > HALF_PI_Q30) begin
      side_nxt.z1    = a1 - PI_Q30;
      side_nxt.flip1 = 1'b1;
    end else if (a1 < -HALF_PI_Q30) begin
      side_nxt.z1    = a1 + PI_Q30;
      side_nxt.flip1 = 1'b1;
    end
    side_nxt.z3    = a3;
    side_nxt.flip3 = 1'b0;
    if (a3 > HALF_PI_Q30) begin
      side_nxt.z3    = a3 - PI_Q30;
      side_nxt.flip3 = 1'b1;
    end else if (a3 < -HALF_PI_Q30) begin
      side_nxt.z3    = a3 + PI_Q30;
      side_nxt.flip3 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r  <= {29'((32'd1 << 28) - c2_sq), 32'd0};
      side0_r <= side_nxt;
    end
  end

  // square-root chain, most significant bit first
  logic        sq_v    [0:SQRT_BITS];
  logic [60:0] sq_rem  [0:SQRT_BITS];
  logic [30:0] sq_root [0:SQRT_BITS];
  sq_side_t    sq_side [0:SQRT_BITS];

  assign sq_v[0]    = v0_r;
  assign sq_rem[0]  = rem0_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = side0_r;

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_sqrt
    ezr_sqrt_cell #(.BIT(SQRT_BITS - 1 - i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_v[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_v[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // CORDIC chain
  logic     cd_v    [0:CORDIC_STEPS];
  cd_st_t   cd_st   [0:CORDIC_STEPS];
  cd_side_t cd_side [0:CORDIC_STEPS];

  always_comb begin
    cd_v[0]          = sq_v[SQRT_BITS];
    cd_st[0].x1      = CORDIC_GAIN;
    cd_st[0].y1      = '0;
    cd_st[0].z1      = sq_side[SQRT_BITS].z1;
    cd_st[0].x3      = CORDIC_GAIN;
    cd_st[0].y3      = '0;
    cd_st[0].z3      = sq_side[SQRT_BITS].z3;
    cd_side[0].pay   = sq_side[SQRT_BITS].pay;
    cd_side[0].s2    = $signed({1'b0, sq_root[SQRT_BITS]});
    cd_side[0].flip1 = sq_side[SQRT_BITS].flip1;
    cd_side[0].flip3 = sq_side[SQRT_BITS].flip3;
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    ezr_cordic_cell #(.STEP(j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (cd_v[j]),
      .st_i   (cd_st[j]),
      .side_i (cd_side[j]),
      .vld_o  (cd_v[j+1]),
      .st_o   (cd_st[j+1]),
      .side_o (cd_side[j+1])
    );
  end

  logic signed [31:0] rot_x, rot_y, rot_z;
  logic               sat;

  ezr_matrix u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (cd_v[CORDIC_STEPS]),
    .st_i   (cd_st[CORDIC_STEPS]),
    .side_i (cd_side[CORDIC_STEPS]),
    .vld_o  (out_tvalid),
    .rot_x  (rot_x),
    .rot_y  (rot_y),
    .rot_z  (rot_z),
    .sat    (sat)
  );

  assign out_tdata = {rot_z, rot_y, rot_x};
  assign out_tuser = sat;

  // saturation flag only with a clipped component
  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      rot_x == SAT_MAX || rot_x == SAT_MIN || rot_y == SAT_MAX ||
      rot_y == SAT_MIN || rot_z == SAT_MAX || rot_z == SAT_MIN)
    else $error("saturated flag without clipped component");

  // middle sine never exceeds unity
  a_s2_range: assert property (@(posedge clk) disable iff (!rst_n)
    cd_v[0] |-> cd_side[0].s2 <= 32'sd1073741824)
    else $error("middle sine out of range");

  // folded angles stay within the CORDIC convergence range
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[0] |-> sq_side[0].z1 <= HALF_PI_Q30 && sq_side[0].z1 >= -HALF_PI_Q30 &&
      sq_side[0].z3 <= HALF_PI_Q30 && sq_side[0].z3 >= -HALF_PI_Q30)
    else $error("angle fold out of range");

endmodule
